>>> design/jdeh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jdeh_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;

    localparam int CODE_W  = 6;
    localparam int RAW_W   = 16;
    localparam int DEPTH_W = 17;
    localparam int SEQ_W   = 32;
    localparam int IDX_W   = 4;
    localparam int DZ_W    = 15;
    localparam int CNT_OUT_W = 5;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    // squaring + fraction bits of the quotient
    localparam int FRAC_W    = 15;
    localparam int SQ_W      = 2 * FRAC_W;
    localparam int DIV_STEPS = FRAC_W;

    localparam logic [DZ_W-1:0]    DZ_CAP    = 15'd32000;
    localparam logic [DZ_W-1:0]    AXIS_FULL = 15'h7FFF;
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = 17'd32768;

    typedef struct packed {
        logic [CODE_W-1:0]         code;
        logic signed [DEPTH_W-1:0] depth;
        logic [SEQ_W-1:0]          seq;
    } hist_entry_t;

    localparam int ENTRY_W = $bits(hist_entry_t);

    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [IDX_W-1:0] rd_index;
        hist_entry_t wr_entry;
    } hist_req_t;

    typedef struct packed {
        logic        rd_valid;
        hist_entry_t rd_entry;
    } hist_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> design/jdeh_sqdiv.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared square / divide unit: squares t, squares d with one multiplier,
// then restoring division of t^2 * 2^15 by d^2, one quotient bit per cycle.
module jdeh_sqdiv (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [jdeh_pkg::FRAC_W-1:0] t_in,
    input  wire logic [jdeh_pkg::FRAC_W-1:0] d_in,
    output logic done,
    output logic [jdeh_pkg::FRAC_W-1:0] quo
);
    import jdeh_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS + 2);
    localparam logic [STEP_W-1:0] STEP_SQ_T = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_SQ_D = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [FRAC_W-1:0]   t_reg, d_reg;
    logic [SQ_W-1:0]     rem_reg, rem_next;
    logic [SQ_W-1:0]     den_reg, den_next;
    logic [FRAC_W-1:0]   quo_reg, quo_next;

    logic [FRAC_W-1:0]   mul_op;
    logic [SQ_W-1:0]     product;
    logic [SQ_W:0]       rem_shift;
    logic                fits;

    assign mul_op    = (step_reg == STEP_SQ_T) ? t_reg : d_reg;
    assign product   = mul_op * mul_op;
    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = STEP_SQ_T;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_SQ_T)
            begin
                rem_next = product;
            end
            else if (step_reg == STEP_SQ_D)
            begin
                den_next = product;
                quo_next = '0;
            end
            else
            begin
                // remainder stays below den, so the difference fits SQ_W bits
                rem_next = fits ? SQ_W'(rem_shift - {1'b0, den_reg}) : rem_shift[SQ_W-1:0];
                quo_next = {quo_reg[FRAC_W-2:0], fits};
            end
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            t_reg <= t_in;
            d_reg <= d_in;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

`ifndef ASSERT_OFF
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("sqdiv done held for more than one cycle");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("sqdiv done without a finished run");
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg && (step_reg == STEP_SQ_T))
        else $error("sqdiv start did not begin a run");
`endif

endmodule

`default_nettype wire

>>> design/jdeh_hist.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular history of recorded events; index 0 on reads is the oldest.
module jdeh_hist #(
    parameter int DEPTH = jdeh_pkg::HISTORY_DEPTH_DEF,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire jdeh_pkg::hist_req_t req,
    output jdeh_pkg::hist_rsp_t rsp,
    output logic [CW-1:0] fill
);
    import jdeh_pkg::*;

    localparam int SW = ((IW > IDX_W) ? IW : IDX_W) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [IW-1:0] HEAD_LAST = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(DEPTH);

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic [IW-1:0]      head_reg, head_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               rd_valid_reg;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic               full;
    logic [SW-1:0]      wr_sum, rd_sum, wr_wrap, rd_wrap;
    logic [IW-1:0]      wr_slot, rd_slot;
    logic               rd_hit;

    assign full    = fill_reg == FILL_FULL;
    assign wr_sum  = SW'(head_reg) + SW'(fill_reg);
    assign rd_sum  = SW'(head_reg) + SW'(req.rd_index);
    assign wr_wrap = (wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum;
    assign rd_wrap = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
    assign wr_slot = full ? head_reg : wr_wrap[IW-1:0];
    assign rd_slot = rd_wrap[IW-1:0];
    assign rd_hit  = SW'(req.rd_index) < SW'(fill_reg);

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (req.wr_en)
        begin
            if (full)
            begin
                head_next = (head_reg == HEAD_LAST) ? '0 : head_reg + IW'(1);
            end
            else
            begin
                fill_next = fill_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            if (req.rd_en)
            begin
                rd_valid_reg <= rd_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_slot] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    assign rsp  = {rd_valid_reg, rd_data_reg};
    assign fill = fill_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("history fill beyond depth");
    a_head_moves_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (req.wr_en && !full) |=> (head_reg == $past(head_reg))
            && (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("append into non-full history moved head or missed fill");
    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> full)
        else $error("full history lost entries");
`endif

endmodule

`default_nettype wire

>>> design/joystick_deadzone_event_history_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Joystick deadzone and event history. An input word with tuser func = 0 is a
// change event: axis inputs get depth ((|v|-dz)/(32767-dz))^2 in Q1.15, clamped
// to 1.0 and zero inside the deadzone (dz = min(cfg, 32000)); buttons pass
// their value through. Events with positive depth are appended to a circular
// history of HISTORY_DEPTH entries, dropping the oldest when full. func = 1
// reads history entry read_index (0 = oldest). One item is in flight at a time:
// an axis event that needs the quotient runs prep, check, a divide step that
// waits on the shared square/divide unit (two squarings, one quotient bit per
// cycle, then a done strobe), write and output steps; an axis event inside
// the deadzone or at full scale goes from check straight to write, buttons go
// to write and reads to a read step (the history RAM read is registered). The
// output word is registered, so the next item is accepted while a result waits
// for m_tready; that item then holds in its output step until the word is taken.
module joystick_deadzone_event_history_top #(
    parameter int HISTORY_DEPTH = jdeh_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    // config: deadzone_level
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [jdeh_pkg::DZ_W-1:0] cfg_data,
    input  wire logic s_tvalid,
    output logic s_tready,
    // input_code[5:0], raw_value[21:6], sequence_number[53:22], read_index[57:54]
    input  wire logic [jdeh_pkg::IN_DATA_W-1:0] s_tdata,
    // func[0], is_axis[1]
    input  wire logic [jdeh_pkg::IN_USER_W-1:0] s_tuser,
    output logic m_tvalid,
    input  wire logic m_tready,
    // depth_out[16:0], recorded[17], entry_valid[18], entry_code[24:19],
    // entry_depth[41:25], entry_sequence[73:42], history_count[78:74]
    output logic [jdeh_pkg::OUT_DATA_W-1:0] m_tdata
);
    import jdeh_pkg::*;

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    state_t state_reg, state_next;

    logic [DZ_W-1:0]           dz_level_reg;
    logic                      func_reg;
    logic                      axis_reg;
    logic [CODE_W-1:0]         code_reg;
    logic signed [RAW_W-1:0]   raw_reg;
    logic [SEQ_W-1:0]          seq_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [DEPTH_W-1:0] t_reg;
    logic [DZ_W-1:0]           d_reg;
    logic signed [DEPTH_W-1:0] depth_reg;
    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    logic                      in_accept;
    logic                      div_start;
    logic                      out_load;
    logic                      div_done;
    logic [FRAC_W-1:0]         div_quo;
    logic                      t_neg;
    logic                      t_sat;
    logic                      depth_pos;
    logic [DZ_W-1:0]           dz_eff;
    logic [DEPTH_W-1:0]        raw_ext;
    logic [DEPTH_W-1:0]        mag;
    hist_req_t                 hreq;
    hist_rsp_t                 hrsp;
    logic [CW-1:0]             hfill;
    logic [CW+CNT_OUT_W-1:0]   fill_ext;
    hist_entry_t               rd_entry;
    logic [OUT_DATA_W-1:0]     out_word;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    assign dz_eff    = (dz_level_reg > DZ_CAP) ? DZ_CAP : dz_level_reg;
    assign raw_ext   = {raw_reg[RAW_W-1], raw_reg};
    assign mag       = raw_reg[RAW_W-1] ? DEPTH_W'(-raw_ext) : raw_ext;
    assign t_neg     = t_reg < 0;
    assign t_sat     = t_reg >= $signed({2'b00, d_reg});
    assign depth_pos = depth_reg > 0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                        state_next = ST_READ;
                    else if (s_tuser[1])
                        state_next = ST_PREP;
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_PREP:  state_next = ST_CHECK;
            ST_CHECK: state_next = (t_neg || t_sat) ? ST_WRITE : ST_DIV;
            ST_DIV:   state_next = div_done ? ST_WRITE : ST_DIV;
            ST_WRITE: state_next = ST_OUT;
            ST_READ:  state_next = ST_OUT;
            ST_OUT:   state_next = (!out_valid_reg || m_tready) ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready            = 1'b0;
        div_start           = 1'b0;
        out_load            = 1'b0;
        hreq.wr_en          = 1'b0;
        hreq.rd_en          = 1'b0;
        hreq.rd_index       = idx_reg;
        hreq.wr_entry.code  = code_reg;
        hreq.wr_entry.depth = depth_reg;
        hreq.wr_entry.seq   = seq_reg;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_CHECK: div_start = !t_neg && !t_sat;
            ST_WRITE: hreq.wr_en = depth_pos;
            ST_READ:  hreq.rd_en = 1'b1;
            ST_OUT:   out_load = !out_valid_reg || m_tready;
            default:  s_tready = 1'b0;
        endcase
    end

    jdeh_sqdiv u_sqdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .t_in  (t_reg[FRAC_W-1:0]),
        .d_in  (d_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    jdeh_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp),
        .fill  (hfill)
    );

    assign fill_ext = (CW + CNT_OUT_W)'(hfill);
    assign rd_entry = hrsp.rd_valid ? hrsp.rd_entry : '0;

    always_comb
    begin
        out_word = '0;
        if (func_reg)
        begin
            out_word[18]    = hrsp.rd_valid;
            out_word[24:19] = rd_entry.code;
            out_word[41:25] = rd_entry.depth;
            out_word[73:42] = rd_entry.seq;
        end
        else
        begin
            out_word[16:0] = depth_reg;
            out_word[17]   = depth_pos;
        end
        out_word[78:74] = fill_ext[CNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dz_level_reg  <= 15'd3276;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                dz_level_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg  <= s_tuser[0];
            axis_reg  <= s_tuser[1];
            code_reg  <= s_tdata[5:0];
            raw_reg   <= s_tdata[21:6];
            seq_reg   <= s_tdata[53:22];
            idx_reg   <= s_tdata[57:54];
            // button depth is the raw value itself
            depth_reg <= {s_tdata[21], s_tdata[21:6]};
        end
        if (state_reg == ST_PREP)
        begin
            t_reg <= $signed(mag - {2'b00, dz_eff});
            d_reg <= AXIS_FULL - dz_eff;
        end
        if (state_reg == ST_CHECK && axis_reg)
        begin
            if (t_neg)
                depth_reg <= '0;
            else if (t_sat)
                depth_reg <= DEPTH_ONE;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            depth_reg <= {2'b00, div_quo};
        end
        if (out_load)
        begin
            out_data_reg <= out_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("second item accepted while one is in flight");
    a_div_only_axis: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> axis_reg && !func_reg)
        else $error("divider started for a non-axis item");
    a_write_only_event: assert property (@(posedge clk) disable iff (!rst_n)
        hreq.wr_en |-> !func_reg && depth_pos)
        else $error("history written by a read or non-positive depth");
`endif

endmodule

`default_nettype wire

>>> tb/sv/joystick_deadzone_event_history_top_tb.sv
`timescale 1ns / 1ps

module joystick_deadzone_event_history_top_tb;

    import jdeh_pkg::*;

    localparam int HIST         = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 125;
    localparam int DZ_RESET     = 3276;
    localparam int DZ_MAX       = 32000;
    localparam int FULL_SCALE   = 32767;
    localparam int DEPTH_CLAMP  = 32768;
    localparam bit OP_EVENT     = 1'b0;
    localparam bit OP_READ      = 1'b1;

    typedef struct packed {
        bit                        func;
        bit                        axis;
        logic [CODE_W-1:0]         code;
        logic signed [RAW_W-1:0]   raw;
        logic [SEQ_W-1:0]          seq;
        logic [IDX_W-1:0]          idx;
    } joy_item_t;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic                      rec;
        logic                      ev;
        logic [CODE_W-1:0]         ecode;
        logic signed [DEPTH_W-1:0] edepth;
        logic [SEQ_W-1:0]          eseq;
        logic [CNT_OUT_W-1:0]      count;
    } joy_result_t;

    typedef struct packed {
        bit          typed;
        joy_result_t r;
    } fixed_check_t;

    typedef struct packed {
        joy_item_t   item;
        bit          typed;
        joy_result_t r;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [DZ_W-1:0]        cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [IN_USER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // predictor state
    int                        dz_level;
    logic [CODE_W-1:0]         hist_code [HIST];
    logic signed [DEPTH_W-1:0] hist_depth [HIST];
    logic [SEQ_W-1:0]          hist_seq [HIST];
    int                        hist_head;
    int                        hist_fill;

    joy_result_t  expected_results [$];
    fixed_check_t fixed_checks [$];
    stim_row_t    directed_rows [$];

    int mismatches;
    int results_seen;
    int cycles;
    int send_burst;
    bit held_off;

    joystick_deadzone_event_history_top #(
        .HISTORY_DEPTH (HIST)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic signed [DEPTH_W-1:0] axis_depth(logic signed [RAW_W-1:0] raw);
        longint mag;
        longint dz;
        longint t;
        longint d;
        longint q;
        mag = raw;
        if (mag < 0)
            mag = -mag;
        dz = (dz_level > DZ_MAX) ? DZ_MAX : dz_level;
        if (mag < dz)
            return '0;
        t = mag - dz;
        d = FULL_SCALE - dz;
        q = ((t * t) << 15) / (d * d);
        if (q > DEPTH_CLAMP)
            q = DEPTH_CLAMP;
        return q[DEPTH_W-1:0];
    endfunction

    // one item through the history; updates predictor state
    function automatic joy_result_t apply_item(joy_item_t it);
        joy_result_t               r;
        logic signed [DEPTH_W-1:0] dep;
        int                        slot;
        r = '0;
        if (it.func == OP_EVENT)
        begin
            dep = it.axis ? axis_depth(it.raw) : {it.raw[RAW_W-1], it.raw};
            r.depth = dep;
            if (dep > 0)
            begin
                if (hist_fill >= HIST)
                begin
                    slot = hist_head;
                    hist_head = (hist_head + 1) % HIST;
                end
                else
                begin
                    slot = (hist_head + hist_fill) % HIST;
                    hist_fill++;
                end
                hist_code[slot]  = it.code;
                hist_depth[slot] = dep;
                hist_seq[slot]   = it.seq;
                r.rec = 1'b1;
            end
        end
        else if (it.idx < hist_fill)
        begin
            slot = (hist_head + it.idx) % HIST;
            r.ev     = 1'b1;
            r.ecode  = hist_code[slot];
            r.edepth = hist_depth[slot];
            r.eseq   = hist_seq[slot];
        end
        r.count = hist_fill[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic joy_item_t mk(bit func, bit axis, int code, int raw,
                                     logic [SEQ_W-1:0] seq, int idx);
        joy_item_t it;
        it.func = func;
        it.axis = axis;
        it.code = code[CODE_W-1:0];
        it.raw  = raw[RAW_W-1:0];
        it.seq  = seq;
        it.idx  = idx[IDX_W-1:0];
        return it;
    endfunction

    function automatic joy_result_t res(int depth, bit rec, bit ev, int ecode, int edepth,
                                        logic [SEQ_W-1:0] eseq, int count);
        joy_result_t r;
        r.depth  = depth[DEPTH_W-1:0];
        r.rec    = rec;
        r.ev     = ev;
        r.ecode  = ecode[CODE_W-1:0];
        r.edepth = edepth[DEPTH_W-1:0];
        r.eseq   = eseq;
        r.count  = count[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic add_row(joy_item_t it, bit typed, joy_result_t r);
        stim_row_t row;
        row.item  = it;
        row.typed = typed;
        row.r     = r;
        directed_rows.push_back(row);
    endtask

    function automatic joy_item_t rand_item();
        joy_item_t it;
        int        sel;
        int        m;
        int        dz;
        it.code = CODE_W'($urandom);
        it.seq  = $urandom;
        it.idx  = IDX_W'($urandom);
        it.axis = 1'($urandom_range(0, 1));
        it.raw  = RAW_W'($urandom);
        it.func = ($urandom_range(0, 99) < 30) ? OP_READ : OP_EVENT;
        if (it.func == OP_READ)
        begin
            if (hist_fill > 0 && $urandom_range(0, 3) != 0)
                it.idx = IDX_W'($urandom_range(0, hist_fill - 1));
        end
        else if (it.axis)
        begin
            sel = $urandom_range(0, 9);
            dz = (dz_level > DZ_MAX) ? DZ_MAX : dz_level;
            if (sel >= 5 && sel <= 7)
            begin
                // hover around the deadzone edge
                m = dz + $urandom_range(0, 80) - 40;
                if (m < 0)
                    m = 0;
                if (m > FULL_SCALE)
                    m = FULL_SCALE;
                it.raw = RAW_W'($urandom_range(0, 1) ? -m : m);
            end
            else if (sel == 8)
                it.raw = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            else if (sel == 9)
                it.raw = RAW_W'($urandom_range(0, 2) - 1);
        end
        else if ($urandom_range(0, 9) < 7)
            it.raw = RAW_W'($urandom_range(1, FULL_SCALE));
        return it;
    endfunction

    function automatic int sender_gap();
        int r;
        if (send_burst > 0)
        begin
            send_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            send_burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(joy_item_t it, bit typed, joy_result_t r);
        int           gap;
        fixed_check_t fc;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        fc.typed = typed;
        fc.r     = r;
        fixed_checks.push_back(fc);
        s_tdata  <= {6'b0, it.idx, it.seq, it.raw, it.code};
        s_tuser  <= {it.axis, it.func};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_deadzone(int value);
        cfg_data  <= value[DZ_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(joy_result_t e, joy_result_t g, string fields);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch on result %0d:%s", results_seen, fields);
            $display("  exp depth=%0d rec=%0d ev=%0d code=%0d edepth=%0d seq=%h cnt=%0d",
                     e.depth, e.rec, e.ev, e.ecode, e.edepth, e.eseq, e.count);
            $display("  got depth=%0d rec=%0d ev=%0d code=%0d edepth=%0d seq=%h cnt=%0d",
                     g.depth, g.rec, g.ev, g.ecode, g.edepth, g.eseq, g.count);
        end
    endtask

    // scoreboard: sample both handshakes and the config write at the rising edge
    always @(posedge clk)
    begin
        joy_result_t  got;
        joy_result_t  exp_r;
        joy_result_t  pred;
        joy_item_t    it;
        fixed_check_t fc;
        string        bad;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.depth  = m_tdata[16:0];
                got.rec    = m_tdata[17];
                got.ev     = m_tdata[18];
                got.ecode  = m_tdata[24:19];
                got.edepth = m_tdata[41:25];
                got.eseq   = m_tdata[73:42];
                got.count  = m_tdata[78:74];
                if (expected_results.size() == 0)
                    note_mismatch('0, got, " unexpected word");
                else
                begin
                    exp_r = expected_results.pop_front();
                    bad = "";
                    if (got.depth !== exp_r.depth)
                        bad = {bad, " depth_out"};
                    if (got.rec !== exp_r.rec)
                        bad = {bad, " recorded"};
                    if (got.ev !== exp_r.ev)
                        bad = {bad, " entry_valid"};
                    if (got.ecode !== exp_r.ecode)
                        bad = {bad, " entry_code"};
                    if (got.edepth !== exp_r.edepth)
                        bad = {bad, " entry_depth"};
                    if (got.eseq !== exp_r.eseq)
                        bad = {bad, " entry_sequence"};
                    if (got.count !== exp_r.count)
                        bad = {bad, " history_count"};
                    if (bad != "")
                        note_mismatch(exp_r, got, bad);
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
                dz_level = cfg_data;
            if (s_tvalid && s_tready)
            begin
                it.func = s_tuser[0];
                it.axis = s_tuser[1];
                it.code = s_tdata[5:0];
                it.raw  = s_tdata[21:6];
                it.seq  = s_tdata[53:22];
                it.idx  = s_tdata[57:54];
                pred = apply_item(it);
                fc = fixed_checks.pop_front();
                expected_results.push_back(fc.typed ? fc.r : pred);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side backpressure, with one long hold-off to fill the block
    initial
    begin
        int r;
        int n;
        bit rdy;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_off && results_seen >= 300)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                rdy = 1'b1;
                n = $urandom_range(50, 150);
            end
            else if (r < 60)
            begin
                rdy = 1'b1;
                n = $urandom_range(1, 6);
            end
            else if (r < 95)
            begin
                rdy = 1'b0;
                n = $urandom_range(1, 4);
            end
            else
            begin
                rdy = 1'b0;
                n = $urandom_range(15, 50);
            end
            m_tready <= rdy;
            repeat (n) @(negedge clk);
        end
    end

    initial
    begin
        int dz_next;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        dz_level   = DZ_RESET;
        hist_head  = 0;
        hist_fill  = 0;
        mismatches = 0;
        results_seen = 0;
        cycles     = 0;
        send_burst = 0;
        held_off   = 1'b0;

        // reset deadzone 3276: full scale span is 29491
        add_row(mk(OP_READ, 0, 1, 100, 32'h1, 0), 1, res(0, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_READ, 1, 2, -5, 32'h2, 15), 1, res(0, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_EVENT, 0, 63, 32767, 32'hFFFF_FFFF, 15), 1,
                res(32767, 1, 0, 0, 0, 0, 1));
        // negative button: reported, not recorded
        add_row(mk(OP_EVENT, 0, 0, -32768, 32'h0, 0), 1, res(-32768, 0, 0, 0, 0, 0, 1));
        add_row(mk(OP_EVENT, 0, 7, 0, 32'h5555_5555, 3), 1, res(0, 0, 0, 0, 0, 0, 1));
        add_row(mk(OP_EVENT, 1, 5, 0, 32'hAAAA_AAAA, 12), 1, res(0, 0, 0, 0, 0, 0, 1));
        add_row(mk(OP_EVENT, 1, 6, 3275, 32'h10, 0), 1, res(0, 0, 0, 0, 0, 0, 1));
        add_row(mk(OP_EVENT, 1, 8, -3276, 32'h11, 0), 1, res(0, 0, 0, 0, 0, 0, 1));
        add_row(mk(OP_EVENT, 1, 42, 32767, 32'h8000_0000, 9), 1,
                res(DEPTH_CLAMP, 1, 0, 0, 0, 0, 2));
        // magnitude 32768 overshoots and clamps
        add_row(mk(OP_EVENT, 1, 21, -32768, 32'h7FFF_FFFF, 6), 1,
                res(DEPTH_CLAMP, 1, 0, 0, 0, 0, 3));
        add_row(mk(OP_EVENT, 1, 9, -20000, 32'h1234_5678, 0), 0, '0);
        add_row(mk(OP_EVENT, 1, 10, 10000, 32'h9ABC_DEF0, 0), 0, '0);
        add_row(mk(OP_EVENT, 1, 11, -3277, 32'h20, 0), 0, '0);
        add_row(mk(OP_EVENT, 0, 12, 1, 32'h21, 0), 1, res(1, 1, 0, 0, 0, 0, 6));
        add_row(mk(OP_READ, 0, 0, 0, 32'h0, 0), 1,
                res(0, 0, 1, 63, 32767, 32'hFFFF_FFFF, 6));
        add_row(mk(OP_READ, 0, 0, 0, 32'h0, 5), 0, '0);
        add_row(mk(OP_READ, 0, 0, 0, 32'h0, 6), 1, res(0, 0, 0, 0, 0, 0, 6));
        add_row(mk(OP_READ, 1, 63, -1, 32'hFFFF_FFFF, 15), 1, res(0, 0, 0, 0, 0, 0, 6));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].r);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: dz_next = 0;
                1: dz_next = DZ_MAX;
                2: dz_next = FULL_SCALE;
                4: dz_next = 1;
                6: dz_next = 16384;
                7: dz_next = DZ_RESET;
                default: dz_next = $urandom_range(0, FULL_SCALE);
            endcase
            write_deadzone(dz_next);
            repeat (PHASE_ITEMS)
                send_word(rand_item(), 0, '0);
            drain();
        end

        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
